[hw/rtl/swpf_pkg.sv]
// Package for the servo write packet framer: state type, packet byte
// constants and CRC settings. No dependencies.
`timescale 1ns / 1ps
package swpf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CrcW       = 16;
  localparam int unsigned PktLen     = 16;
  localparam int unsigned CntW       = $clog2(PktLen);
  localparam int unsigned ParamCount = 6;

  localparam logic [CrcW-1:0]  CrcPoly    = 16'h8005;
  localparam logic [CrcW-1:0]  CrcInit    = 16'h0000;
  localparam logic [ByteW-1:0] HdrFf      = 8'hFF;
  localparam logic [ByteW-1:0] HdrFd      = 8'hFD;
  localparam logic [ByteW-1:0] HdrRsv     = 8'h00;
  localparam logic [ByteW-1:0] LenLo      = 8'(5 + 4);
  localparam logic [ByteW-1:0] LenHi      = 8'h00;
  localparam logic [ByteW-1:0] InstrReset = 8'h03;

  // Byte positions within the packet
  localparam logic [CntW-1:0] PosHdr0   = 4'd0;
  localparam logic [CntW-1:0] PosHdr1   = 4'd1;
  localparam logic [CntW-1:0] PosHdr2   = 4'd2;
  localparam logic [CntW-1:0] PosRsv    = 4'd3;
  localparam logic [CntW-1:0] PosId     = 4'd4;
  localparam logic [CntW-1:0] PosLenLo  = 4'd5;
  localparam logic [CntW-1:0] PosLenHi  = 4'd6;
  localparam logic [CntW-1:0] PosInstr  = 4'd7;
  localparam logic [CntW-1:0] PosAddrLo = 4'd8;
  localparam logic [CntW-1:0] PosAddrHi = 4'd9;
  localparam logic [CntW-1:0] PosVal0   = 4'd10;
  localparam logic [CntW-1:0] PosVal1   = 4'd11;
  localparam logic [CntW-1:0] PosVal2   = 4'd12;
  localparam logic [CntW-1:0] PosVal3   = 4'd13;
  localparam logic [CntW-1:0] PosCrcLo  = 4'd14;
  localparam logic [CntW-1:0] PosCrcHi  = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEND
  } state_t;

  // Control from the sequencer to the CRC unit
  typedef struct packed {
    logic clr;
    logic en;
  } crc_ctl_t;

endpackage

[hw/rtl/swpf_crc_unit.sv]
// Shared CRC-16 unit (poly 0x8005, no reflection): folds one byte per
// enabled cycle into its running value, cleared by clr. Depends on swpf_pkg.
`timescale 1ns / 1ps
module swpf_crc_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swpf_pkg::crc_ctl_t           ctl,
  input  logic [swpf_pkg::ByteW-1:0]   data,
  output logic [swpf_pkg::CrcW-1:0]    crc
);

  logic [swpf_pkg::CrcW-1:0] crc_r;
  logic [swpf_pkg::CrcW-1:0] crc_nxt;
  logic [swpf_pkg::CrcW-1:0] fold;

  // Shift one byte through the polynomial, one bit a step
  always_comb begin
    fold = crc_r ^ {data, {(swpf_pkg::CrcW-swpf_pkg::ByteW){1'b0}}};
    for (int k = 0; k < swpf_pkg::ByteW; k++) begin
      if (fold[swpf_pkg::CrcW-1]) begin
        fold = {fold[swpf_pkg::CrcW-2:0], 1'b0} ^ swpf_pkg::CrcPoly;
      end else begin
        fold = {fold[swpf_pkg::CrcW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clr) begin
      crc_nxt = swpf_pkg::CrcInit;
    end else if (ctl.en) begin
      crc_nxt = fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= swpf_pkg::CrcInit;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

[hw/rtl/servo_write_packet_framer_crc16_top.sv]
// Servo register-write packet framer with CRC-16 (top level).
// Depends on swpf_pkg and swpf_crc_unit.
`timescale 1ns / 1ps
// A command word is accepted in ST_IDLE, checked in ST_CHECK for the
// FF FF FD pattern in the parameter bytes, then sent in ST_SEND as the
// packet, one byte word per cycle while out_tready stays high. A command
// whose parameters hold FF FF FD would need a stuffed byte, no longer
// fits the 16-byte packet, and is dropped after the check with no
// output. The CRC is built by one shared byte-wide unit that folds in
// each byte before the CRC bytes as it leaves. in_tready is low from
// acceptance until the last byte word is taken or the command is dropped.
module servo_write_packet_framer_crc16_top (
  input  logic        clk,
  input  logic        rst_n,
  // Command input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [7:0] dev_id, [23:8] register_address,
                                  // [55:24] write_value
  // Packet byte output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,  // last_byte
  // Instruction register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int unsigned BW = swpf_pkg::ByteW;
  localparam int unsigned CW = swpf_pkg::CntW;

  swpf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [BW-1:0]    instr_r;
  logic [BW-1:0]    id_r;
  logic [15:0]      addr_r;
  logic [31:0]      val_r;
  logic [BW-1:0]    prm [swpf_pkg::ParamCount];
  logic             stuff_hit;
  logic [BW-1:0]    byte_sel;
  logic [swpf_pkg::CrcW-1:0] crc;
  swpf_pkg::crc_ctl_t        crc_ctl;
  logic             in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // Instruction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      instr_r <= swpf_pkg::InstrReset;
    end else if (cfg_wr_en) begin
      instr_r <= cfg_wr_data;
    end
  end

  // Hold the command fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r   <= in_tdata[7:0];
      addr_r <= in_tdata[23:8];
      val_r  <= in_tdata[55:24];
    end
  end

  // Look for FF FF FD starting at any of parameter bytes 0 to 3
  always_comb begin
    prm[0] = addr_r[7:0];
    prm[1] = addr_r[15:8];
    prm[2] = val_r[7:0];
    prm[3] = val_r[15:8];
    prm[4] = val_r[23:16];
    prm[5] = val_r[31:24];
    stuff_hit = 1'b0;
    for (int j = 0; j + 2 < swpf_pkg::ParamCount; j++) begin
      if (prm[j] == swpf_pkg::HdrFf && prm[j+1] == swpf_pkg::HdrFf &&
          prm[j+2] == swpf_pkg::HdrFd) begin
        stuff_hit = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      swpf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = swpf_pkg::ST_CHECK;
        end
      end
      swpf_pkg::ST_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = stuff_hit ? swpf_pkg::ST_IDLE : swpf_pkg::ST_SEND;
      end
      swpf_pkg::ST_SEND: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == swpf_pkg::PosCrcHi) begin
            state_nxt = swpf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = swpf_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    crc_ctl.clr = 1'b0;
    crc_ctl.en  = 1'b0;
    case (state_r)
      swpf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      swpf_pkg::ST_CHECK: begin
        crc_ctl.clr = 1'b1;
      end
      swpf_pkg::ST_SEND: begin
        out_tvalid = 1'b1;
        crc_ctl.en = out_acc && (cnt_r < swpf_pkg::PosCrcLo);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swpf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Select the packet byte at the current position
  always_comb begin
    case (cnt_r)
      swpf_pkg::PosHdr0:   byte_sel = swpf_pkg::HdrFf;
      swpf_pkg::PosHdr1:   byte_sel = swpf_pkg::HdrFf;
      swpf_pkg::PosHdr2:   byte_sel = swpf_pkg::HdrFd;
      swpf_pkg::PosRsv:    byte_sel = swpf_pkg::HdrRsv;
      swpf_pkg::PosId:     byte_sel = id_r;
      swpf_pkg::PosLenLo:  byte_sel = swpf_pkg::LenLo;
      swpf_pkg::PosLenHi:  byte_sel = swpf_pkg::LenHi;
      swpf_pkg::PosInstr:  byte_sel = instr_r;
      swpf_pkg::PosAddrLo: byte_sel = addr_r[7:0];
      swpf_pkg::PosAddrHi: byte_sel = addr_r[15:8];
      swpf_pkg::PosVal0:   byte_sel = val_r[7:0];
      swpf_pkg::PosVal1:   byte_sel = val_r[15:8];
      swpf_pkg::PosVal2:   byte_sel = val_r[23:16];
      swpf_pkg::PosVal3:   byte_sel = val_r[31:24];
      swpf_pkg::PosCrcLo:  byte_sel = crc[7:0];
      swpf_pkg::PosCrcHi:  byte_sel = crc[15:8];
      default:             byte_sel = swpf_pkg::HdrRsv;
    endcase
  end

  swpf_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .data  (byte_sel),
    .crc   (crc)
  );

  assign out_tdata = byte_sel;
  assign out_tlast = (state_r == swpf_pkg::ST_SEND) && (cnt_r == swpf_pkg::PosCrcHi);

`ifndef ASSERT_OFF
  // Never take a command while a packet is going out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("command accepted during packet output");

  // The last byte word ends the packet
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> !out_tvalid)
    else $error("output continues after last byte");

  // A stalled byte word keeps its position and the CRC holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(cnt_r) && $stable(crc)))
    else $error("position or CRC moved during stall");

  // A packet always starts at the first header byte
  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> (cnt_r == swpf_pkg::PosHdr0))
    else $error("packet started mid-frame");
`endif

endmodule
